// ===== sv/svm_pkg.sv =====
package svm_pkg;

  // default store sizes
  localparam int unsigned CODE_WORDS_DEF     = 1024;
  localparam int unsigned STACK_DEPTH_DEF    = 256;
  localparam int unsigned CALL_DEPTH_DEF     = 64;
  localparam int unsigned GLOBAL_SLOTS_DEF   = 64;
  localparam int unsigned FUNCTION_SLOTS_DEF = 32;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 11;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MAIN_INDEX     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FUNCTION_TOTAL = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GLOBAL_TOTAL   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CODE_TOTAL     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_STRING_TOTAL   = 3'd4;

  // request modes
  localparam logic [1:0] MODE_LOAD_CODE = 2'd0;
  localparam logic [1:0] MODE_LOAD_FUNC = 2'd1;
  localparam logic [1:0] MODE_START     = 2'd2;
  localparam logic [1:0] MODE_STEP      = 2'd3;

  // result status
  localparam logic [2:0] ST_RAN   = 3'd0;
  localparam logic [2:0] ST_PINT  = 3'd1;
  localparam logic [2:0] ST_PSTR  = 3'd2;
  localparam logic [2:0] ST_HALT  = 3'd3;
  localparam logic [2:0] ST_ERROR = 3'd4;

  // fault codes
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_MAIN      = 4'd1;
  localparam logic [3:0] ERR_UNDERFLOW = 4'd2;
  localparam logic [3:0] ERR_OVERFLOW  = 4'd3;
  localparam logic [3:0] ERR_GLOBAL    = 4'd4;
  localparam logic [3:0] ERR_ADDRESS   = 4'd5;
  localparam logic [3:0] ERR_CALL      = 4'd6;
  localparam logic [3:0] ERR_CALLFULL  = 4'd7;
  localparam logic [3:0] ERR_STRING    = 4'd8;
  localparam logic [3:0] ERR_OPCODE    = 4'd9;
  localparam logic [3:0] ERR_FLOW      = 4'd10;

  // opcodes
  localparam logic [31:0] OP_NOP    = 32'd0;
  localparam logic [31:0] OP_PUSH   = 32'd1;
  localparam logic [31:0] OP_LDG    = 32'd2;
  localparam logic [31:0] OP_STG    = 32'd3;
  localparam logic [31:0] OP_LDI    = 32'd4;
  localparam logic [31:0] OP_STI    = 32'd5;
  localparam logic [31:0] OP_ADD    = 32'd6;
  localparam logic [31:0] OP_SUB    = 32'd7;
  localparam logic [31:0] OP_MUL    = 32'd8;
  localparam logic [31:0] OP_AND    = 32'd9;
  localparam logic [31:0] OP_OR     = 32'd10;
  localparam logic [31:0] OP_XOR    = 32'd11;
  localparam logic [31:0] OP_SHL    = 32'd12;
  localparam logic [31:0] OP_SHR    = 32'd13;
  localparam logic [31:0] OP_EQ     = 32'd14;
  localparam logic [31:0] OP_NE     = 32'd15;
  localparam logic [31:0] OP_LT     = 32'd16;
  localparam logic [31:0] OP_GT     = 32'd17;
  localparam logic [31:0] OP_LE     = 32'd18;
  localparam logic [31:0] OP_GE     = 32'd19;
  localparam logic [31:0] OP_NEG    = 32'd20;
  localparam logic [31:0] OP_JMP    = 32'd21;
  localparam logic [31:0] OP_JZ     = 32'd22;
  localparam logic [31:0] OP_CALL   = 32'd23;
  localparam logic [31:0] OP_RET    = 32'd24;
  localparam logic [31:0] OP_POP    = 32'd25;
  localparam logic [31:0] OP_PSTR   = 32'd26;
  localparam logic [31:0] OP_PINT   = 32'd27;

  typedef struct packed {
    logic load;
    logic start;
    logic notrun;
    logic flow;
    logic fetch;
    logic issue;
    logic exec;
    logic ind;
    logic clr;
    logic out_load;
  } svm_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       running;
    logic       ip_ok;
    logic       ind_go;
    logic       clr_last;
    logic       out_free;
  } svm_stat_t;

endpackage

// ===== sv/svm_ctrl.sv =====
module svm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  svm_pkg::svm_stat_t st,
  output svm_pkg::svm_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_EXEC  = 6'b000100,
    S_IND   = 6'b001000,
    S_CLR   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (st.mode)
            svm_pkg::MODE_LOAD_CODE, svm_pkg::MODE_LOAD_FUNC: begin
              cmd.load  = 1'b1;
              state_nxt = S_DONE;
            end
            svm_pkg::MODE_START: begin
              cmd.start = 1'b1;
              state_nxt = S_CLR;
            end
            default: begin
              if (!st.running) begin
                cmd.notrun = 1'b1;
                state_nxt  = S_DONE;
              end else if (!st.ip_ok) begin
                cmd.flow  = 1'b1;
                state_nxt = S_DONE;
              end else begin
                cmd.fetch = 1'b1;
                state_nxt = S_FETCH;
              end
            end
          endcase
        end
      end
      S_FETCH: begin
        cmd.issue = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (st.ind_go) begin
          state_nxt = S_IND;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_IND: begin
        cmd.ind   = 1'b1;
        state_nxt = S_DONE;
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/svm_dp.sv =====
module svm_dp #(
  parameter int unsigned CODE_WORDS     = svm_pkg::CODE_WORDS_DEF,
  parameter int unsigned STACK_DEPTH    = svm_pkg::STACK_DEPTH_DEF,
  parameter int unsigned CALL_DEPTH     = svm_pkg::CALL_DEPTH_DEF,
  parameter int unsigned GLOBAL_SLOTS   = svm_pkg::GLOBAL_SLOTS_DEF,
  parameter int unsigned FUNCTION_SLOTS = svm_pkg::FUNCTION_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [svm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               cfg_wr_en,
  input  logic [svm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [svm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [svm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  svm_pkg::svm_cmd_t                  cmd,
  output svm_pkg::svm_stat_t                 st
);

  localparam int unsigned CW  = (CODE_WORDS > 1) ? $clog2(CODE_WORDS) : 1;
  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SDW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RAW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int unsigned RDW = $clog2(CALL_DEPTH + 1);
  localparam int unsigned GW  = (GLOBAL_SLOTS > 1) ? $clog2(GLOBAL_SLOTS) : 1;
  localparam int unsigned FW  = (FUNCTION_SLOTS > 1) ? $clog2(FUNCTION_SLOTS) : 1;

  // request fields
  logic [1:0]  in_mode;
  logic [31:0] in_loc;
  logic [31:0] in_word;
  logic        in_flag;
  assign in_mode = in_tdata[1:0];
  assign in_loc  = 32'(in_tdata[11:2]);
  assign in_word = in_tdata[43:12];
  assign in_flag = in_tdata[44];

  // configuration
  logic [4:0]  main_r;
  logic [5:0]  ftot_r;
  logic [6:0]  gtot_r;
  logic [10:0] ctot_r;
  logic [8:0]  stot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_r <= '0;
      ftot_r <= '0;
      gtot_r <= '0;
      ctot_r <= '0;
      stot_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        svm_pkg::REG_MAIN_INDEX:     main_r <= cfg_wdata[4:0];
        svm_pkg::REG_FUNCTION_TOTAL: ftot_r <= cfg_wdata[5:0];
        svm_pkg::REG_GLOBAL_TOTAL:   gtot_r <= cfg_wdata[6:0];
        svm_pkg::REG_CODE_TOTAL:     ctot_r <= cfg_wdata[10:0];
        svm_pkg::REG_STRING_TOTAL:   stot_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ccount, gcount, fcount;
  assign ccount = (32'(ctot_r) < CODE_WORDS)     ? 32'(ctot_r) : CODE_WORDS;
  assign gcount = (32'(gtot_r) < GLOBAL_SLOTS)   ? 32'(gtot_r) : GLOBAL_SLOTS;
  assign fcount = (32'(ftot_r) < FUNCTION_SLOTS) ? 32'(ftot_r) : FUNCTION_SLOTS;

  // machine state
  logic [31:0]    ip_r;
  logic [SDW-1:0] sd_r;
  logic [RDW-1:0] rd_r;
  logic [3:0]     fault_r;
  logic           run_r;
  logic [GW-1:0]  clr_r;
  logic [2:0]     res_status_r;
  logic [31:0]    res_value_r;

  // memories
  logic [31:0] code_mem [CODE_WORDS];
  logic [31:0] fent_mem [FUNCTION_SLOTS];
  logic [31:0] stk_mem  [STACK_DEPTH];
  logic [31:0] ret_mem  [CALL_DEPTH];
  logic [31:0] glb_mem  [GLOBAL_SLOTS];
  logic [FUNCTION_SLOTS-1:0] fdecl_r;

  logic [31:0] op_q, arg_q, fent_q, top_q, nxt_q, ret_q, glb_q;
  logic [31:0] ip_p1;
  logic [SDW-1:0] sd_m1, sd_m2;
  logic [RDW-1:0] rd_m1;
  assign ip_p1 = ip_r + 32'd1;
  assign sd_m1 = sd_r - SDW'(1);
  assign sd_m2 = sd_r - SDW'(2);
  assign rd_m1 = rd_r - RDW'(1);

  // opcode and argument are held for the whole step
  always_ff @(posedge clk) begin
    if (cmd.load && in_mode == svm_pkg::MODE_LOAD_CODE && in_loc < CODE_WORDS) begin
      code_mem[in_loc[CW-1:0]] <= in_word;
    end
    if (cmd.fetch) begin
      op_q  <= code_mem[ip_r[CW-1:0]];
      arg_q <= code_mem[ip_p1[CW-1:0]];
    end
  end

  logic [FW-1:0] fra;
  assign fra = (cmd.start || cmd.clr) ? FW'(main_r) : arg_q[FW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load && in_mode == svm_pkg::MODE_LOAD_FUNC && in_loc < FUNCTION_SLOTS) begin
      fent_mem[in_loc[FW-1:0]] <= in_word;
    end
    fent_q <= fent_mem[fra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fdecl_r <= '0;
    end else if (cmd.load && in_mode == svm_pkg::MODE_LOAD_FUNC &&
                 in_loc < FUNCTION_SLOTS) begin
      fdecl_r[in_loc[FW-1:0]] <= in_flag;
    end
  end

  // execute decode
  logic [3:0]     x_err;
  logic           x_halt;
  logic [SDW-1:0] x_sd;
  logic           x_swe;
  logic [SAW-1:0] x_saddr;
  logic [31:0]    x_sdata;
  logic           x_gwe;
  logic [GW-1:0]  x_gaddr;
  logic [31:0]    x_gdata;
  logic           x_ipwe;
  logic [31:0]    x_ip;
  logic [RDW-1:0] x_rd;
  logic           x_rwe;
  logic [2:0]     x_status;
  logic [31:0]    x_value;
  logic [31:0]    alu_y, mul_y, shr_y;
  logic           sd0, sd_lt2, sfull;
  logic signed [31:0] sa, sb;

  assign sd0    = (sd_r == '0);
  assign sd_lt2 = (32'(sd_r) < 32'd2);
  assign sfull  = (32'(sd_r) >= STACK_DEPTH);
  assign sa     = nxt_q;
  assign sb     = top_q;
  assign mul_y  = nxt_q * top_q;
  assign shr_y  = 32'(sa >>> top_q[4:0]);

  always_comb begin
    case (op_q)
      svm_pkg::OP_ADD: alu_y = nxt_q + top_q;
      svm_pkg::OP_SUB: alu_y = nxt_q - top_q;
      svm_pkg::OP_MUL: alu_y = mul_y;
      svm_pkg::OP_AND: alu_y = nxt_q & top_q;
      svm_pkg::OP_OR:  alu_y = nxt_q | top_q;
      svm_pkg::OP_XOR: alu_y = nxt_q ^ top_q;
      svm_pkg::OP_SHL: alu_y = nxt_q << top_q[4:0];
      svm_pkg::OP_SHR: alu_y = shr_y;
      svm_pkg::OP_EQ:  alu_y = 32'(sa == sb);
      svm_pkg::OP_NE:  alu_y = 32'(sa != sb);
      svm_pkg::OP_LT:  alu_y = 32'(sa < sb);
      svm_pkg::OP_GT:  alu_y = 32'(sa > sb);
      svm_pkg::OP_LE:  alu_y = 32'(sa <= sb);
      default:         alu_y = 32'(sa >= sb);
    endcase
  end

  always_comb begin
    x_err    = svm_pkg::ERR_NONE;
    x_halt   = 1'b0;
    x_sd     = sd_r;
    x_swe    = 1'b0;
    x_saddr  = sd_r[SAW-1:0];
    x_sdata  = arg_q;
    x_gwe    = 1'b0;
    x_gaddr  = arg_q[GW-1:0];
    x_gdata  = top_q;
    x_ipwe   = 1'b0;
    x_ip     = arg_q;
    x_rd     = rd_r;
    x_rwe    = 1'b0;
    x_status = svm_pkg::ST_RAN;
    x_value  = '0;
    case (op_q)
      svm_pkg::OP_NOP: ;
      svm_pkg::OP_PUSH: begin
        if (sfull) x_err = svm_pkg::ERR_OVERFLOW;
        else begin
          x_swe = 1'b1;
          x_sd  = sd_r + SDW'(1);
        end
      end
      svm_pkg::OP_LDG: begin
        if (arg_q >= gcount) x_err = svm_pkg::ERR_GLOBAL;
        else if (sfull) x_err = svm_pkg::ERR_OVERFLOW;
        else begin
          x_swe   = 1'b1;
          x_sdata = glb_q;
          x_sd    = sd_r + SDW'(1);
        end
      end
      svm_pkg::OP_STG: begin
        if (sd0) x_err = svm_pkg::ERR_UNDERFLOW;
        else if (arg_q >= gcount) x_err = svm_pkg::ERR_GLOBAL;
        else begin
          x_gwe = 1'b1;
          x_sd  = sd_m1;
        end
      end
      svm_pkg::OP_LDI: begin
        // valid case goes through the indirect read state
        if (sd0) x_err = svm_pkg::ERR_UNDERFLOW;
        else x_err = svm_pkg::ERR_ADDRESS;
      end
      svm_pkg::OP_STI: begin
        if (sd_lt2) x_err = svm_pkg::ERR_UNDERFLOW;
        else if (nxt_q >= gcount) x_err = svm_pkg::ERR_ADDRESS;
        else begin
          x_gwe   = 1'b1;
          x_gaddr = nxt_q[GW-1:0];
          x_sd    = sd_m2;
        end
      end
      svm_pkg::OP_ADD, svm_pkg::OP_SUB, svm_pkg::OP_MUL, svm_pkg::OP_AND,
      svm_pkg::OP_OR, svm_pkg::OP_XOR, svm_pkg::OP_SHL, svm_pkg::OP_SHR,
      svm_pkg::OP_EQ, svm_pkg::OP_NE, svm_pkg::OP_LT, svm_pkg::OP_GT,
      svm_pkg::OP_LE, svm_pkg::OP_GE: begin
        if (sd_lt2) x_err = svm_pkg::ERR_UNDERFLOW;
        else begin
          x_swe   = 1'b1;
          x_saddr = sd_m2[SAW-1:0];
          x_sdata = alu_y;
          x_sd    = sd_m1;
        end
      end
      svm_pkg::OP_NEG: begin
        if (sd0) x_err = svm_pkg::ERR_UNDERFLOW;
        else begin
          x_swe   = 1'b1;
          x_saddr = sd_m1[SAW-1:0];
          x_sdata = 32'd0 - top_q;
        end
      end
      svm_pkg::OP_JMP: x_ipwe = 1'b1;
      svm_pkg::OP_JZ: begin
        if (sd0) x_err = svm_pkg::ERR_UNDERFLOW;
        else begin
          x_sd   = sd_m1;
          x_ipwe = (top_q == 32'd0);
        end
      end
      svm_pkg::OP_CALL: begin
        if (arg_q >= fcount || !fdecl_r[arg_q[FW-1:0]]) x_err = svm_pkg::ERR_CALL;
        else if (32'(rd_r) >= CALL_DEPTH) x_err = svm_pkg::ERR_CALLFULL;
        else begin
          x_rwe  = 1'b1;
          x_rd   = rd_r + RDW'(1);
          x_ipwe = 1'b1;
          x_ip   = fent_q;
        end
      end
      svm_pkg::OP_RET: begin
        if (rd_r == '0) begin
          x_halt   = 1'b1;
          x_status = svm_pkg::ST_HALT;
        end else begin
          // return value replaces the top, or is pushed onto an empty stack
          x_rd    = rd_m1;
          x_ipwe  = 1'b1;
          x_ip    = ret_q;
          x_swe   = 1'b1;
          x_sdata = sd0 ? 32'd0 : top_q;
          x_saddr = sd0 ? '0 : sd_m1[SAW-1:0];
          x_sd    = sd0 ? SDW'(1) : sd_r;
        end
      end
      svm_pkg::OP_POP: begin
        if (sd0) x_err = svm_pkg::ERR_UNDERFLOW;
        else x_sd = sd_m1;
      end
      svm_pkg::OP_PSTR: begin
        if (arg_q >= 32'(stot_r)) x_err = svm_pkg::ERR_STRING;
        else begin
          x_status = svm_pkg::ST_PSTR;
          x_value  = arg_q;
        end
      end
      svm_pkg::OP_PINT: begin
        if (sd0) x_err = svm_pkg::ERR_UNDERFLOW;
        else begin
          x_sd     = sd_m1;
          x_status = svm_pkg::ST_PINT;
          x_value  = top_q;
        end
      end
      default: x_err = svm_pkg::ERR_OPCODE;
    endcase
    if (x_err != svm_pkg::ERR_NONE) begin
      x_status = svm_pkg::ST_ERROR;
      x_value  = '0;
      x_swe    = 1'b0;
      x_gwe    = 1'b0;
      x_rwe    = 1'b0;
      x_ipwe   = 1'b0;
    end
  end

  // operand and return stacks
  always_ff @(posedge clk) begin
    if ((cmd.exec && x_swe) || cmd.ind) begin
      stk_mem[cmd.ind ? sd_m1[SAW-1:0] : x_saddr] <= cmd.ind ? glb_q : x_sdata;
    end
    top_q <= stk_mem[sd_m1[SAW-1:0]];
    nxt_q <= stk_mem[sd_m2[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && x_rwe) begin
      ret_mem[rd_r[RAW-1:0]] <= ip_r;
    end
    ret_q <= ret_mem[rd_m1[RAW-1:0]];
  end

  // globals: zeroed by a sweep after start
  logic [GW-1:0] gra;
  assign gra = cmd.issue ? arg_q[GW-1:0] : top_q[GW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      glb_mem[clr_r] <= '0;
    end else if (cmd.exec && x_gwe) begin
      glb_mem[x_gaddr] <= x_gdata;
    end
    glb_q <= glb_mem[gra];
  end

  assign st.mode     = in_mode;
  assign st.running  = run_r;
  assign st.ip_ok    = !ip_r[31] && ({1'b0, ip_r} + 33'd1 < {1'b0, ccount});
  assign st.ind_go   = (op_q == svm_pkg::OP_LDI) && !sd0 && (top_q < gcount);
  assign st.clr_last = (32'(clr_r) == GLOBAL_SLOTS - 1);
  assign st.out_free = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_r    <= '0;
      sd_r    <= '0;
      rd_r    <= '0;
      fault_r <= svm_pkg::ERR_NONE;
      run_r   <= 1'b0;
      clr_r   <= '0;
    end else begin
      if (cmd.start) begin
        ip_r    <= '0;
        sd_r    <= '0;
        rd_r    <= '0;
        fault_r <= svm_pkg::ERR_NONE;
        run_r   <= 1'b0;
        clr_r   <= '0;
      end
      if (cmd.clr) begin
        clr_r <= clr_r + GW'(1);
        if (st.clr_last) begin
          if (32'(main_r) >= fcount) begin
            fault_r <= svm_pkg::ERR_MAIN;
          end else begin
            ip_r  <= fent_q;
            run_r <= 1'b1;
          end
        end
      end
      if (cmd.flow) begin
        fault_r <= svm_pkg::ERR_FLOW;
        run_r   <= 1'b0;
      end
      if (cmd.fetch) begin
        ip_r <= ip_r + 32'd2;
      end
      if (cmd.exec) begin
        sd_r <= x_sd;
        rd_r <= x_rd;
        if (x_ipwe) ip_r <= x_ip;
        if (x_err != svm_pkg::ERR_NONE) begin
          fault_r <= x_err;
          run_r   <= 1'b0;
        end
        if (x_halt) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.start) begin
      res_status_r <= svm_pkg::ST_RAN;
      res_value_r  <= '0;
    end
    if (cmd.clr && st.clr_last && 32'(main_r) >= fcount) begin
      res_status_r <= svm_pkg::ST_ERROR;
    end
    if (cmd.notrun) begin
      res_status_r <= (fault_r != svm_pkg::ERR_NONE) ? svm_pkg::ST_ERROR : svm_pkg::ST_HALT;
      res_value_r  <= '0;
    end
    if (cmd.flow) begin
      res_status_r <= svm_pkg::ST_ERROR;
      res_value_r  <= '0;
    end
    if (cmd.exec) begin
      res_status_r <= x_status;
      res_value_r  <= x_value;
    end
    if (cmd.ind) begin
      res_status_r <= svm_pkg::ST_RAN;
      res_value_r  <= '0;
    end
  end

  // result register
  logic        out_valid_r;
  logic [70:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {ip_r, fault_r, res_value_r, res_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

endmodule

// ===== sv/stack_bytecode_vm_step.sv =====
// step request: fetch / stack read / execute sequence over registered memory reads, plus an
// indirect read state for an indirect global load; a request is taken only in idle, so the next
// one waits for the result to be loaded; loads go straight to the result; start clears the
// globals one slot per cycle, taking no request meanwhile (configuration writes still land)
// rst_n is synchronous and active low; it clears control state, declared flags and counts,
// the code, function, stack and global stores keep their contents
module stack_bytecode_vm_step #(
  parameter int unsigned CODE_WORDS     = svm_pkg::CODE_WORDS_DEF,
  parameter int unsigned STACK_DEPTH    = svm_pkg::STACK_DEPTH_DEF,
  parameter int unsigned CALL_DEPTH     = svm_pkg::CALL_DEPTH_DEF,
  parameter int unsigned GLOBAL_SLOTS   = svm_pkg::GLOBAL_SLOTS_DEF,
  parameter int unsigned FUNCTION_SLOTS = svm_pkg::FUNCTION_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // mode[1:0], location[11:2], word[43:12], declared_flag[44], zero pad
  input  logic [svm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[2:0], value[34:3], error_code[38:35], next_ip[70:39], zero pad
  output logic [svm_pkg::OUT_TDATA_W-1:0] out_tdata,
  // register writes
  input  logic                            cfg_wr_en,
  input  logic [svm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [svm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // controller to datapath commands and status back
  svm_pkg::svm_cmd_t  cmd;
  svm_pkg::svm_stat_t st;

  // sequencer: idle, fetch, stack read, execute, indirect read, clear, result
  svm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // stores, stack pointers, alu and the result register
  svm_dp #(
    .CODE_WORDS     (CODE_WORDS),
    .STACK_DEPTH    (STACK_DEPTH),
    .CALL_DEPTH     (CALL_DEPTH),
    .GLOBAL_SLOTS   (GLOBAL_SLOTS),
    .FUNCTION_SLOTS (FUNCTION_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule
